/* design/akpr_pkg.sv */
package akpr_pkg;

    // ARX state geometry
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned NUM_WORDS = 4;

    // Coefficient format: Q0.15 magnitude, Q1.15 signed after quadrant folding
    localparam int unsigned FRAC_BITS     = 15;
    localparam int unsigned COEF_MAG_BITS = 15;
    localparam int unsigned COEF_BITS     = COEF_MAG_BITS + 1;
    localparam int unsigned Q30_BITS      = 30;
    localparam int unsigned TAYLOR_ORDER  = 14;
    localparam logic [63:0] PI_HALF_Q30   = 64'd1686629713;
    localparam logic [COEF_MAG_BITS-1:0] Q15_MAX = '1;

    // Configuration index width
    localparam int unsigned CFG_IDX_BITS = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [NUM_WORDS-1:0][WORD_BITS-1:0] t_words;

    localparam t_words SEED_RESET = {32'h6b206574, 32'h79203233,
                                     32'h3320646e, 32'h61707865};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SEED_0,
        REG_SEED_1,
        REG_SEED_2,
        REG_SEED_3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    function automatic t_word rotl32(t_word x, int unsigned s);
        return (x << s) | (x >> (WORD_BITS - s));
    endfunction

    // One quarter round over the four words
    function automatic t_words arx_round(t_words w);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_words res;
        a = w[0];
        b = w[1];
        c = w[2];
        d = w[3];
        a = a + b; d = d ^ a; d = rotl32(d, 16);
        c = c + d; b = b ^ c; b = rotl32(b, 12);
        a = a + b; d = d ^ a; d = rotl32(d, 8);
        c = c + d; b = b ^ c; b = rotl32(b, 7);
        res[0] = a;
        res[1] = b;
        res[2] = c;
        res[3] = d;
        return res;
    endfunction

    // Q2.30 to a Q0.15 magnitude, round half up, clamp to [0, 1)
    function automatic logic [COEF_MAG_BITS-1:0] q30_to_q15(logic signed [63:0] v);
        logic signed [63:0] x;
        if (v < 0) begin
            return '0;
        end
        x = (v + 64'sd16384) >>> FRAC_BITS;
        if (x > 64'sd32767) begin
            return Q15_MAX;
        end
        return x[COEF_MAG_BITS-1:0];
    endfunction

    // Elaboration-time Taylor series for cos/sin of one first-quadrant step.
    // Returns {cos, sin} as Q0.15 magnitudes.
    function automatic logic [2*COEF_MAG_BITS-1:0] taylor_coef(int unsigned r,
                                                               int unsigned pb);
        logic [63:0] t;
        logic [63:0] term;
        logic signed [63:0] cacc;
        logic signed [63:0] sacc;
        logic [COEF_MAG_BITS-1:0] c;
        logic [COEF_MAG_BITS-1:0] s;
        t    = (64'(r) * PI_HALF_Q30) >> (pb - 2);
        term = 64'd1 << Q30_BITS;
        cacc = $signed(term);
        sacc = '0;
        for (int k = 1; k <= TAYLOR_ORDER; k++) begin
            term = ((term * t) >> Q30_BITS) / 64'(k);
            if (k[0]) begin
                if (k[1]) sacc = sacc - $signed(term);
                else      sacc = sacc + $signed(term);
            end else begin
                if (k[1]) cacc = cacc - $signed(term);
                else      cacc = cacc + $signed(term);
            end
        end
        c = q30_to_q15(cacc);
        s = q30_to_q15(sacc);
        return {c, s};
    endfunction

endpackage

/* design/akpr_if.sv */
interface akpr_sym_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] symbol_i;
    logic signed [SAMPLE_BITS-1:0] symbol_q;
    logic                          frame_start;

    modport source (output valid, output symbol_i, output symbol_q,
                    output frame_start, input ready);
    modport sink   (input valid, input symbol_i, input symbol_q,
                    input frame_start, output ready);
endinterface

interface akpr_sym_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] rotated_i;
    logic signed [SAMPLE_BITS-1:0] rotated_q;

    modport source (output valid, output rotated_i, output rotated_q, input ready);
    modport sink   (input valid, input rotated_i, input rotated_q, output ready);
endinterface

interface akpr_cfg_if
    import akpr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [WORD_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/arx_keyed_phase_rotator.sv */
// Channel   Direction  Transaction contents
// i_sym     in         symbol_i, symbol_q (signed), frame_start
// o_rot     out        rotated_i, rotated_q (signed, rounded, saturated)
// i_cfg     in         index (seed word 0..3), data (32-bit seed)
//
// One symbol per clock sustained while the output is not stalled; each symbol
// passes through the phase, coefficient, product and round/saturate registers.
// The quarter round on the ARX words completes in the accepting cycle.
// Synchronous active-low reset restores seeds and ARX words to defaults.
// A stalled output holds; upstream stages keep filling until all are full.
// Configuration writes are always taken.
module arx_keyed_phase_rotator
    import akpr_pkg::*;
#(
    parameter int PHASE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    akpr_sym_in_if.sink     i_sym,
    akpr_sym_out_if.source  o_rot,
    akpr_cfg_if.sink        i_cfg
);

    localparam int FRAC_W = PHASE_BITS - 2;
    localparam int QUART  = 1 << FRAC_W;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q_W    = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [Q_W-1:0]   SAT_HI     = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_LO     = -SAT_HI - Q_W'(1);

    // Seed registers and running ARX state
    t_words r_seed;
    t_words r_words;
    t_words n_words;

    // Pipeline registers
    logic                          r_v1;
    logic [PHASE_BITS-1:0]         r_p1;
    logic signed [SAMPLE_BITS-1:0] r_i1;
    logic signed [SAMPLE_BITS-1:0] r_q1;

    logic                          r_v2;
    logic signed [COEF_BITS-1:0]   r_cs2;
    logic signed [COEF_BITS-1:0]   r_sn2;
    logic signed [SAMPLE_BITS-1:0] r_i2;
    logic signed [SAMPLE_BITS-1:0] r_q2;

    logic                          r_v3;
    logic signed [PROD_W-1:0]      r_ic3;
    logic signed [PROD_W-1:0]      r_qs3;
    logic signed [PROD_W-1:0]      r_is3;
    logic signed [PROD_W-1:0]      r_qc3;

    logic                          r_vo;
    logic signed [SAMPLE_BITS-1:0] r_ri;
    logic signed [SAMPLE_BITS-1:0] r_rq;

    // Handshake
    logic rdy_o;
    logic rdy3;
    logic rdy2;
    logic rdy1;
    logic in_acc;

    // Coefficient path
    logic [COEF_MAG_BITS-1:0]    cos_lut [QUART];
    logic [COEF_MAG_BITS-1:0]    sin_lut [QUART];
    t_quad                       quad;
    logic [FRAC_W-1:0]           frac;
    logic signed [COEF_BITS-1:0] c_val;
    logic signed [COEF_BITS-1:0] s_val;
    logic signed [COEF_BITS-1:0] n_cs;
    logic signed [COEF_BITS-1:0] n_sn;

    // Products and results
    logic signed [PROD_W-1:0]      n_ic;
    logic signed [PROD_W-1:0]      n_qs;
    logic signed [PROD_W-1:0]      n_is;
    logic signed [PROD_W-1:0]      n_qc;
    logic signed [SAMPLE_BITS-1:0] n_ri;
    logic signed [SAMPLE_BITS-1:0] n_rq;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] x;
        logic signed [Q_W-1:0]   q;
        x = acc + ROUND_HALF;
        q = Q_W'(x >>> FRAC_BITS);
        priority if (q > SAT_HI) return SAT_HI[SAMPLE_BITS-1:0];
        else if (q < SAT_LO)     return SAT_LO[SAMPLE_BITS-1:0];
        else                     return q[SAMPLE_BITS-1:0];
    endfunction

    // Build the first-quadrant cos/sin table at elaboration
    for (genvar g = 0; g < QUART; g++) begin : g_lut
        localparam logic [2*COEF_MAG_BITS-1:0] CS = taylor_coef(g, PHASE_BITS);
        assign cos_lut[g] = CS[2*COEF_MAG_BITS-1 -: COEF_MAG_BITS];
        assign sin_lut[g] = CS[COEF_MAG_BITS-1:0];
    end

    // Ready chain: each stage moves when the next one has room
    assign rdy_o       = !r_vo || o_rot.ready;
    assign rdy3        = !r_v3 || rdy_o;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign in_acc      = i_sym.valid && rdy1;
    assign i_sym.ready = rdy1;
    assign i_cfg.ready = 1'b1;

    assign o_rot.valid     = r_vo;
    assign o_rot.rotated_i = r_ri;
    assign o_rot.rotated_q = r_rq;

    // Quarter round on the seeds at frame start, else on the running words
    assign n_words = arx_round(i_sym.frame_start ? r_seed : r_words);

    // Hold seeds; take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_SEED_0: r_seed[0] <= i_cfg.data;
                REG_SEED_1: r_seed[1] <= i_cfg.data;
                REG_SEED_2: r_seed[2] <= i_cfg.data;
                REG_SEED_3: r_seed[3] <= i_cfg.data;
                default:    r_seed    <= r_seed;
            endcase
        end
    end

    // Advance ARX state once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= SEED_RESET;
        end else if (in_acc) begin
            r_words <= n_words;
        end
    end

    // Look up the quadrant coefficients and fold by quadrant
    always_comb begin
        quad  = t_quad'(r_p1[PHASE_BITS-1 -: 2]);
        frac  = r_p1[FRAC_W-1:0];
        c_val = $signed({1'b0, cos_lut[frac]});
        s_val = $signed({1'b0, sin_lut[frac]});
        unique case (quad)
            QUAD_0: begin n_cs = c_val;  n_sn = s_val;  end
            QUAD_1: begin n_cs = -s_val; n_sn = c_val;  end
            QUAD_2: begin n_cs = -c_val; n_sn = -s_val; end
            QUAD_3: begin n_cs = s_val;  n_sn = -c_val; end
            default: begin n_cs = c_val; n_sn = s_val;  end
        endcase
    end

    // Four partial products
    always_comb begin
        n_ic = r_i2 * r_cs2;
        n_qs = r_q2 * r_sn2;
        n_is = r_i2 * r_sn2;
        n_qc = r_q2 * r_cs2;
    end

    // Combine, round and saturate
    always_comb begin
        n_ri = round_sat(ACC_W'(r_ic3) - ACC_W'(r_qs3));
        n_rq = round_sat(ACC_W'(r_is3) + ACC_W'(r_qc3));
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1)  r_v1 <= in_acc;
            if (rdy2)  r_v2 <= r_v1;
            if (rdy3)  r_v3 <= r_v2;
            if (rdy_o) r_vo <= r_v3;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1 <= n_words[0][WORD_BITS-1 -: PHASE_BITS];
            r_i1 <= i_sym.symbol_i;
            r_q1 <= i_sym.symbol_q;
        end
        if (r_v1 && rdy2) begin
            r_cs2 <= n_cs;
            r_sn2 <= n_sn;
            r_i2  <= r_i1;
            r_q2  <= r_q1;
        end
        if (r_v2 && rdy3) begin
            r_ic3 <= n_ic;
            r_qs3 <= n_qs;
            r_is3 <= n_is;
            r_qc3 <= n_qc;
        end
        if (r_v3 && rdy_o) begin
            r_ri <= n_ri;
            r_rq <= n_rq;
        end
    end

endmodule

/* design/akpr_checker.sv */
module akpr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_rot_i,
    input logic [SAMPLE_BITS-1:0] i_rot_q,
    input logic                   i_cfg_ready
);

    localparam logic [2:0] MAX_INFLIGHT = 3'd4;

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    // Track transactions taken in but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready)    n_cnt = n_cnt + 3'd1;
        if (i_out_valid && i_out_ready)  n_cnt = n_cnt - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // No result without an outstanding input
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 3'd0))
        else $error("result shown with nothing in flight");

    // Pipeline depth bounds the number in flight
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_INFLIGHT)
        else $error("more transactions in flight than pipeline stages");

    // Input is refused only while the output is stalled
    a_refuse_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input refused without output back-pressure");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rot_i) && $stable(i_rot_q)))
        else $error("stalled result changed");

    // Configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind arx_keyed_phase_rotator akpr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_akpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sym.valid),
    .i_in_ready  (i_sym.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_rot_i     (o_rot.rotated_i),
    .i_rot_q     (o_rot.rotated_q),
    .i_cfg_ready (i_cfg.ready)
);

/* dv/arx_keyed_phase_rotator_tb.sv */
module arx_keyed_phase_rotator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import akpr_pkg::*;

    localparam int PHASE_BITS      = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int SAMPLE_MAX      = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN      = -(2 ** (SAMPLE_BITS - 1));
    localparam int TAYLOR_TERMS    = 14;
    localparam int HOLD_OFF_CYCLES = 48;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 80;
    localparam int TIMEOUT_NS      = 400_000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam t_word DEFAULT_SEED_0 = 32'h61707865;
    localparam t_word DEFAULT_SEED_1 = 32'h3320646e;
    localparam t_word DEFAULT_SEED_2 = 32'h79203233;
    localparam t_word DEFAULT_SEED_3 = 32'h6b206574;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef longint unsigned t_u64;

    typedef struct packed {
        t_sample rot_i;
        t_sample rot_q;
    } t_rotated;

    logic clk = 1'b0;
    logic rst_n;

    akpr_sym_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sym_if ();
    akpr_sym_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) rot_if ();
    akpr_cfg_if                                  cfg_if ();

    arx_keyed_phase_rotator #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sym   (sym_if),
        .o_rot   (rot_if),
        .i_cfg   (cfg_if)
    );

    // Seed registers and keystream words as the block should hold them
    t_word       seed_regs [NUM_WORDS];
    t_word       key_words [NUM_WORDS];
    t_rotated    pending_rotations [$];

    int unsigned fail_count;
    int unsigned symbol_count;
    int unsigned frame_count;
    int unsigned seed_settings;
    int unsigned checked_count;
    int unsigned saturated_count;

    bit sender_idle_on;
    bit receiver_idle_on;
    bit hold_off_req;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_word rol32(t_word x, int unsigned n);
        logic [2*WORD_BITS-1:0] dbl;
        dbl = {x, x} << n;
        return dbl[2*WORD_BITS-1 -: WORD_BITS];
    endfunction

    // Q2.30 to a Q0.15 magnitude, round half up, clamp to [0, 32767]
    function automatic longint q30_to_coef(longint v);
        longint r;
        if (v < 0) begin
            return 0;
        end
        r = (v + 16384) >>> 15;
        return (r > 32767) ? 32767 : r;
    endfunction

    // Round half towards plus infinity, then clamp to the sample range
    function automatic t_sample round_sample(longint acc);
        longint q;
        q = (acc + 16384) >>> 15;
        if (q > SAMPLE_MAX) begin
            q = SAMPLE_MAX;
        end else if (q < SAMPLE_MIN) begin
            q = SAMPLE_MIN;
        end
        return t_sample'(q);
    endfunction

    // Advance the keystream by one symbol and rotate that symbol by its phase
    function automatic t_rotated rotate_next(t_sample sym_i, t_sample sym_q, logic new_frame);
        t_word                 a, b, c, d;
        logic [PHASE_BITS-1:0] phase;
        longint unsigned       angle;
        longint unsigned       term;
        longint                cos_acc, sin_acc, c_mag, s_mag, cos_v, sin_v;
        t_rotated              res;
        if (new_frame) begin
            foreach (key_words[k]) key_words[k] = seed_regs[k];
        end
        // one quarter round: add, xor, rotate
        a = key_words[0];
        b = key_words[1];
        c = key_words[2];
        d = key_words[3];
        a = a + b; d = rol32(d ^ a, 16);
        c = c + d; b = rol32(b ^ c, 12);
        a = a + b; d = rol32(d ^ a, 8);
        c = c + d; b = rol32(b ^ c, 7);
        key_words[0] = a;
        key_words[1] = b;
        key_words[2] = c;
        key_words[3] = d;
        // top bits of the new first word pick the phase
        phase = a[WORD_BITS-1 -: PHASE_BITS];
        angle = (t_u64'(phase[PHASE_BITS-3:0]) * HALF_PI_Q30) >> (PHASE_BITS - 2);
        // first-quadrant cos/sin by Taylor series in Q2.30
        term    = 64'd1 << 30;
        cos_acc = longint'(term);
        sin_acc = 0;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * angle) >> 30) / t_u64'(k);
            case (k % 4)
                0: cos_acc = cos_acc + longint'(term);
                1: sin_acc = sin_acc + longint'(term);
                2: cos_acc = cos_acc - longint'(term);
                default: sin_acc = sin_acc - longint'(term);
            endcase
        end
        c_mag = q30_to_coef(cos_acc);
        s_mag = q30_to_coef(sin_acc);
        // fold into the quadrant given by the top two phase bits
        case (t_quad'(phase[PHASE_BITS-1 -: 2]))
            QUAD_0: begin
                cos_v = c_mag;  sin_v = s_mag;
            end
            QUAD_1: begin
                cos_v = -s_mag; sin_v = c_mag;
            end
            QUAD_2: begin
                cos_v = -c_mag; sin_v = -s_mag;
            end
            default: begin
                cos_v = s_mag;  sin_v = -c_mag;
            end
        endcase
        res.rot_i = round_sample(longint'(sym_i) * cos_v - longint'(sym_q) * sin_v);
        res.rot_q = round_sample(longint'(sym_i) * sin_v + longint'(sym_q) * cos_v);
        return res;
    endfunction

    // Mostly full-range values, with the extremes and values near zero mixed in
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return t_sample'(SAMPLE_MAX);
            1: return t_sample'(SAMPLE_MIN);
            2: return t_sample'(int'($urandom_range(0, 8)) - 4);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Offer one symbol, hold it until taken, then record its expected rotation
    task automatic send_symbol(t_sample sym_i, t_sample sym_q, logic new_frame);
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            sym_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sym_if.valid       <= 1'b1;
        sym_if.symbol_i    <= sym_i;
        sym_if.symbol_q    <= sym_q;
        sym_if.frame_start <= new_frame;
        do @(posedge clk); while (sym_if.ready !== 1'b1);
        pending_rotations.push_back(rotate_next(sym_i, sym_q, new_frame));
        symbol_count++;
        if (new_frame) begin
            frame_count++;
        end
    endtask

    // Drop valid and wait until every pending rotation has come out
    task automatic wait_drain();
        sym_if.valid <= 1'b0;
        do @(posedge clk); while (pending_rotations.size() != 0);
    endtask

    task automatic write_seed(t_cfg_reg idx, t_word value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        seed_regs[idx] = value;
    endtask

    task automatic load_seeds(t_word w0, t_word w1, t_word w2, t_word w3);
        write_seed(REG_SEED_0, w0);
        write_seed(REG_SEED_1, w1);
        write_seed(REG_SEED_2, w2);
        write_seed(REG_SEED_3, w3);
        cfg_if.valid <= 1'b0;
        seed_settings++;
    endtask

    // Keystream straight out of reset, no frame start yet
    task automatic test_reset_state();
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), 1'b0);
        send_symbol(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MIN), 1'b0);
        send_symbol(t_sample'(0), t_sample'(0), 1'b0);
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b0);
        send_symbol(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MAX), 1'b0);
        send_symbol(t_sample'(1), t_sample'(-1), 1'b0);
    endtask

    // Reload from the default seeds, including back-to-back frame starts
    task automatic test_frame_reload();
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(0), 1'b1);
        send_symbol(t_sample'(0), t_sample'(SAMPLE_MAX), 1'b0);
        send_symbol(t_sample'(-1), t_sample'(1), 1'b0);
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), 1'b1);
        send_symbol(t_sample'(SAMPLE_MIN), t_sample'(0), 1'b1);
        send_symbol(t_sample'(1), t_sample'(1), 1'b0);
        wait_drain();
    endtask

    // All-zero seeds keep the phase at zero (unity gain as 32767); all-ones seeds
    task automatic test_seed_extremes();
        wait_drain();
        load_seeds('0, '0, '0, '0);
        send_symbol(t_sample'(1), t_sample'(0), 1'b1);
        send_symbol(t_sample'(-1), t_sample'(0), 1'b0);
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b0);
        send_symbol(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MIN), 1'b0);
        wait_drain();
        load_seeds('1, '1, '1, '1);
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), 1'b1);
        send_symbol(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MIN), 1'b0);
        send_symbol(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b0);
        send_symbol(t_sample'(3), t_sample'(-3), 1'b0);
        wait_drain();
        load_seeds(DEFAULT_SEED_0, DEFAULT_SEED_1, DEFAULT_SEED_2, DEFAULT_SEED_3);
    endtask

    // Hold the output off for a long stretch while symbols keep arriving
    task automatic test_backpressure();
        bit idle_saved;
        idle_saved     = sender_idle_on;
        sender_idle_on = 1'b0;
        hold_off_req   = 1'b1;
        repeat (24) send_symbol(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
        sender_idle_on = idle_saved;
        wait_drain();
    endtask

    // Frames of random length and content under several seed settings
    task automatic test_random_frames();
        int unsigned count;
        int unsigned frame_len;
        bit          start_frame;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drain();
            // last phase runs flat out on both sides
            if (ph == RANDOM_PHASES - 1) begin
                sender_idle_on   = 1'b0;
                receiver_idle_on = 1'b0;
            end
            if (ph == 2) begin
                load_seeds('1, '0, 32'h8000_0000, 32'h7fff_ffff);
            end else begin
                load_seeds($urandom, $urandom, $urandom, $urandom);
            end
            count = 0;
            while (count < PHASE_ITEMS) begin
                frame_len   = $urandom_range(1, 24);
                // now and then a frame runs on without a reload
                start_frame = ($urandom_range(0, 7) != 0);
                for (int k = 0; k < frame_len && count < PHASE_ITEMS; k++) begin
                    send_symbol(pick_sample(), pick_sample(),
                                (k == 0) ? start_frame : ($urandom_range(0, 15) == 0));
                    count++;
                end
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin : receiver
        rot_if.ready = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                rot_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
                rot_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end else begin
                rot_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted rotation with the oldest one pending
    always @(posedge clk) begin : rotation_check
        t_rotated want;
        if (rst_n === 1'b1 && rot_if.valid === 1'b1 && rot_if.ready === 1'b1) begin
            if (pending_rotations.size() == 0) begin
                $error("rotated symbol with none pending: rotated_i=%0d rotated_q=%0d",
                       rot_if.rotated_i, rot_if.rotated_q);
                fail_count++;
            end else begin
                want = pending_rotations.pop_front();
                checked_count++;
                if (want.rot_i == SAMPLE_MAX || want.rot_i == SAMPLE_MIN ||
                    want.rot_q == SAMPLE_MAX || want.rot_q == SAMPLE_MIN) begin
                    saturated_count++;
                end
                if (rot_if.rotated_i !== want.rot_i) begin
                    $error("rotated_i mismatch: expected %0d, actual %0d",
                           want.rot_i, rot_if.rotated_i);
                    fail_count++;
                end
                if (rot_if.rotated_q !== want.rot_q) begin
                    $error("rotated_q mismatch: expected %0d, actual %0d",
                           want.rot_q, rot_if.rotated_q);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("arx_keyed_phase_rotator test failed");
        $finish;
    end

    initial begin : run
        rst_n              = 1'b0;
        sym_if.valid       = 1'b0;
        sym_if.symbol_i    = '0;
        sym_if.symbol_q    = '0;
        sym_if.frame_start = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_SEED_0;
        cfg_if.data        = '0;
        sender_idle_on     = 1'b1;
        receiver_idle_on   = 1'b1;
        hold_off_req       = 1'b0;
        seed_regs[0]       = DEFAULT_SEED_0;
        seed_regs[1]       = DEFAULT_SEED_1;
        seed_regs[2]       = DEFAULT_SEED_2;
        seed_regs[3]       = DEFAULT_SEED_3;
        foreach (key_words[k]) key_words[k] = seed_regs[k];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_frame_reload();
        test_seed_extremes();
        test_backpressure();
        test_random_frames();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d symbols with %0d frame starts over %0d seed settings.",
                 symbol_count, frame_count, seed_settings);
        $display("Checked %0d rotated symbols, %0d of them at a saturation bound.",
                 checked_count, saturated_count);
        if (fail_count == 0) begin
            $display("arx_keyed_phase_rotator test passed");
        end else begin
            $display("arx_keyed_phase_rotator test failed");
        end
        $finish;
    end

endmodule
